// ===== hdl/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, constants and functions for the read-back pattern checker:
// run length, CRC-32 parameters, register indexes, status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package prc_pkg;

    // expected run length and the width of the byte counter, which saturates one above it
    localparam int unsigned TOTAL_BYTES = 4096;
    localparam int unsigned COUNT_W     = $clog2(TOTAL_BYTES + 2);

    localparam logic [COUNT_W-1:0] COUNT_TOTAL = COUNT_W'(TOTAL_BYTES);

    // CRC-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // configuration register reset values
    localparam logic [7:0] MULT_RESET = 8'd37;
    localparam logic [7:0] ADD_RESET  = 8'd91;

    // configuration port widths
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_MULT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_ADD  = CFG_INDEX_W'(1);

    // result status codes
    typedef enum logic [1:0] {
        STATUS_PASS     = 2'd0,
        STATUS_LENGTH   = 2'd1,
        STATUS_MISMATCH = 2'd2
    } status_t;

    // output stream payload: status then crc, padded to whole bytes
    localparam int unsigned OUT_TDATA_W = 40;

    // pattern configuration as seen by the checker
    typedef struct packed {
        logic [7:0] mult;
        logic [7:0] add;
    } pattern_cfg_t;

    // absorb one byte, least significant bit first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data_in);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data_in};
        for (int k = 0; k < 8; k++)
        begin
            crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'd0);
        end
        return crc;
    endfunction

endpackage : prc_pkg

`default_nettype wire

// ===== hdl/prc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// prc_cfg_regs
// Pattern configuration registers, written through the configuration
// channel; indexes beyond the list are accepted and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_cfg_regs
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [prc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [prc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output prc_pkg::pattern_cfg_t              pattern_cfg
);
    import prc_pkg::*;

    logic [7:0] mult_reg, mult_next;
    logic [7:0] add_reg,  add_next;

    // always ready: every write is accepted when offered
    assign cfg_ready = 1'b1;

    // decode the write
    always_comb
    begin
        mult_next = mult_reg;
        add_next  = add_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PATTERN_MULT: mult_next = cfg_data[7:0];
                REG_PATTERN_ADD:  add_next  = cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= MULT_RESET;
            add_reg  <= ADD_RESET;
        end
        else
        begin
            mult_reg <= mult_next;
            add_reg  <= add_next;
        end
    end

    assign pattern_cfg.mult = mult_reg;
    assign pattern_cfg.add  = add_reg;

endmodule : prc_cfg_regs

`default_nettype wire

// ===== hdl/prc_run_check.sv =====
// ----------------------------------------------------------------------------
// prc_run_check
// Run state (byte count, CRC, mismatch flag) and the result register.
// Compares the registered byte with the pattern, advances the CRC and
// loads a result on the last byte of a run.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_run_check
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  prc_pkg::pattern_cfg_t        pattern_cfg,
    input  wire                          item_valid,
    input  wire  [7:0]                   item_data,
    input  wire                          item_last,
    output logic                         item_take,
    output logic                         res_valid,
    input  wire                          res_ready,
    output prc_pkg::status_t             res_status,
    output logic [31:0]                  res_crc
);
    import prc_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [31:0]        crc_reg,   crc_next;
    logic               mism_reg,  mism_next;

    logic               out_valid_reg, out_valid_next;
    status_t            status_reg,    status_next;
    logic [31:0]        crc_out_reg,   crc_out_next;

    logic [15:0]        product;
    logic [7:0]         expect_byte;
    logic               byte_match;
    logic [COUNT_W-1:0] count_inc;
    logic               mism_upd;
    logic [31:0]        crc_upd;
    logic               slot_free;

    // expected pattern byte at the current offset
    assign product     = count_reg[7:0] * pattern_cfg.mult;
    assign expect_byte = product[7:0] + pattern_cfg.add;
    assign byte_match  = (item_data == expect_byte);

    // advance run state for this byte
    assign count_inc = (count_reg <= COUNT_TOTAL) ? count_reg + COUNT_W'(1) : count_reg;
    assign mism_upd  = mism_reg | ~byte_match;
    assign crc_upd   = mism_upd ? crc_reg : crc_byte(crc_reg, item_data);

    // take a byte unless it ends a run and the result slot is still full
    assign slot_free = ~out_valid_reg | res_ready;
    assign item_take = item_valid & (~item_last | slot_free);

    always_comb
    begin
        count_next     = count_reg;
        crc_next       = crc_reg;
        mism_next      = mism_reg;
        out_valid_next = out_valid_reg & ~res_ready;
        status_next    = status_reg;
        crc_out_next   = crc_out_reg;
        if (item_take)
        begin
            if (item_last)
            begin
                // load the result and clear the run
                out_valid_next = 1'b1;
                if (count_inc != COUNT_TOTAL)
                    status_next = STATUS_LENGTH;
                else if (mism_upd)
                    status_next = STATUS_MISMATCH;
                else
                    status_next = STATUS_PASS;
                crc_out_next = ~crc_upd;
                count_next   = '0;
                crc_next     = CRC_INIT;
                mism_next    = 1'b0;
            end
            else
            begin
                count_next = count_inc;
                crc_next   = crc_upd;
                mism_next  = mism_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            crc_reg       <= CRC_INIT;
            mism_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            mism_reg      <= mism_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        crc_out_reg <= crc_out_next;
    end

    assign res_valid  = out_valid_reg;
    assign res_status = status_reg;
    assign res_crc    = crc_out_reg;

    // the counter never passes one above the run length
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_TOTAL + COUNT_W'(1))
        else $error("byte count beyond saturation");

    // a run end always leaves a result and a cleared run
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && item_last |=> out_valid_reg && count_reg == '0
            && crc_reg == CRC_INIT && !mism_reg)
        else $error("run end did not load result or clear state");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_ready |-> !(item_take && item_last))
        else $error("pending result overwritten");

    // once a mismatch is seen the CRC stays frozen until the run ends
    a_crc_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        mism_reg && !(item_take && item_last) |=> $stable(crc_reg))
        else $error("CRC moved after mismatch");

endmodule : prc_run_check

`default_nettype wire

// ===== hdl/pattern_readback_crc32_checker.sv =====
// ----------------------------------------------------------------------------
// pattern_readback_crc32_checker
// Checks a read-back byte stream against the pattern (k*mult + add) mod 256
// and reports pass / wrong length / mismatch with the inverted CRC-32.
//
//   channel   direction  payload
//   s_axis    in         tdata[7:0] data_byte, tlast last_byte
//   m_axis    out        tdata[1:0] status, tdata[33:2] crc_value
//   cfg       in         cfg_index (0 pattern_mult, 1 pattern_add), cfg_data
//
// One item per cycle sustained while the result stream is not stalled. A byte is
// compared and folded into the CRC while it is held in the input register; the
// result item is valid from the edge that takes the last byte out of that register.
// Reset clears the run state and loads the pattern defaults (37, 91).
// A stalled result holds the byte that ends the next run in the input
// register, and the input stalls behind it until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pattern_readback_crc32_checker
(
    input  wire                                    clk,
    input  wire                                    rst_n,
    // input stream
    input  wire                                    s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire  [7:0]                             s_axis_tdata,   // [7:0] data_byte
    input  wire                                    s_axis_tlast,
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire                                    m_axis_tready,
    output logic [prc_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,   // [1:0] status, [33:2] crc_value
    // configuration
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire  [prc_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire  [prc_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import prc_pkg::*;

    pattern_cfg_t pattern_cfg;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    logic       item_take;
    status_t    res_status;
    logic [31:0] res_crc;

    prc_cfg_regs u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pattern_cfg (pattern_cfg)
    );

    // input register: refill whenever it is empty or the held item moves on
    assign s_axis_tready = ~in_valid_reg | item_take;
    assign in_valid_next = s_axis_tvalid | (in_valid_reg & ~item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    prc_run_check u_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pattern_cfg (pattern_cfg),
        .item_valid  (in_valid_reg),
        .item_data   (in_data_reg),
        .item_last   (in_last_reg),
        .item_take   (item_take),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_status  (res_status),
        .res_crc     (res_crc)
    );

    // pack the result item
    assign m_axis_tdata = {6'd0, res_crc, res_status};

endmodule : pattern_readback_crc32_checker

`default_nettype wire
